// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on the rising edge and held off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsk_pkg.sv =====
`default_nettype none
package rsk_pkg;

  localparam int unsigned FUNC_W          = 3;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned SCORE_W         = 10;
  localparam int unsigned SERIES_W        = 8;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned MEAN_W          = 10;
  localparam int unsigned DEF_STACK_DEPTH = 16;

  localparam int unsigned IN_BITS = FUNC_W + ID_W + SCORE_W + SERIES_W;
  localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_LOOKUP  = 3'd2,
    FUNC_EXTRACT = 3'd3,
    FUNC_AVERAGE = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [SCORE_W-1:0]  score;
    logic [SERIES_W-1:0] series;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_AVG,
    S_OUT
  } state_e;

  // result item width, padded to whole bytes
  function automatic int unsigned out_width(int unsigned cnt_w);
    int unsigned bits;
    bits = STATUS_W + REC_W + cnt_w + MEAN_W;
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/record_stack_with_keyed_removal.sv =====
`default_nettype none
// Bounded LIFO of records {id, score, series} held in a single synchronous RAM, one operation
// at a time. A result waits in an output register so the next item is taken as soon as the
// operation finishes, unless an earlier result still waits there. Lookup reads one entry a
// cycle from the top down. Extract adds a shift of the entries above the match, one RAM read
// and write a cycle. Average runs a restoring divider, one quotient bit a cycle. There is no
// clearing pass after reset.
module record_stack_with_keyed_removal
  import rsk_pkg::*;
#(
  parameter  int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OUT_W       = out_width(CNT_W)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // func, rec_id, score, series
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // status, out_id, out_score, out_series, depth_now, mean_score
  output logic      [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned TOT_W = SCORE_W + CNT_W;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [ID_W-1:0]    key_q, key_d;
  logic               extract_q, extract_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic               more_q, more_d;
  logic               rd_vld_q, rd_vld_d;
  status_e            status_q, status_d;
  rec_t               rec_q, rec_d;
  logic [MEAN_W-1:0]  mean_q, mean_d;
  logic               m_valid_q, m_valid_d;
  logic [OUT_W-1:0]   m_data_q, m_data_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [REC_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [REC_W-1:0]   ram_rdata;
  rec_t               rd_rec;

  logic               div_start;
  logic               div_done;
  logic [MEAN_W-1:0]  div_quot;

  logic               in_acc;
  func_e              in_func;
  rec_t               in_rec;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   idx_p1;
  logic [CNT_W-1:0]   ptr_p1;

  rsk_ram #(
    .WIDTH (REC_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rsk_div #(
    .DEN_W (CNT_W),
    .Q_W   (MEAN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (total_q),
    .den_i   (count_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_func       = func_e'(s_axis_tdata[FUNC_W-1:0]);
  assign in_rec.id     = s_axis_tdata[FUNC_W +: ID_W];
  assign in_rec.score  = s_axis_tdata[FUNC_W+ID_W +: SCORE_W];
  assign in_rec.series = s_axis_tdata[FUNC_W+ID_W+SCORE_W +: SERIES_W];
  assign rd_rec        = rec_t'(ram_rdata);

  assign cnt_m1 = count_q - CNT_W'(1);
  assign idx_p1 = CNT_W'(rd_idx_q) + CNT_W'(1);
  assign ptr_p1 = CNT_W'(ptr_q) + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    total_d   = total_q;
    key_d     = key_q;
    extract_d = extract_q;
    ptr_d     = ptr_q;
    rd_idx_d  = rd_idx_q;
    more_d    = more_q;
    rd_vld_d  = rd_vld_q;
    status_d  = status_q;
    rec_d     = rec_q;
    mean_d    = mean_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q - AW'(1);
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = ST_OK;
          rec_d    = '0;
          mean_d   = '0;
          state_d  = S_OUT;
          case (in_func)
            FUNC_PUSH: begin
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = in_rec;
                count_d   = count_q + CNT_W'(1);
                total_d   = total_q + TOT_W'(in_rec.score);
              end
            end
            FUNC_POP: begin
              if (count_q == '0) begin
                status_d = ST_MISS;
              end else begin
                ram_raddr = cnt_m1[AW-1:0];
                state_d   = S_POP;
              end
            end
            FUNC_LOOKUP, FUNC_EXTRACT: begin
              if (count_q == '0) begin
                status_d = ST_MISS;
              end else begin
                key_d     = in_rec.id;
                extract_d = (in_func == FUNC_EXTRACT);
                ptr_d     = cnt_m1[AW-1:0];
                more_d    = 1'b1;
                rd_vld_d  = 1'b0;
                state_d   = S_SCAN;
              end
            end
            FUNC_AVERAGE: begin
              if (count_q != '0) begin
                div_start = 1'b1;
                state_d   = S_AVG;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        rec_d   = rd_rec;
        count_d = cnt_m1;
        total_d = total_q - TOT_W'(rd_rec.score);
        state_d = S_OUT;
      end
      S_SCAN: begin
        rd_vld_d = more_q;
        rd_idx_d = ptr_q;
        if (more_q) begin
          ptr_d  = ptr_q - AW'(1);
          more_d = (ptr_q != '0);
        end
        if (rd_vld_q) begin
          if (rd_rec.id == key_q) begin
            rec_d = rd_rec;
            if (extract_q) begin
              ptr_d    = idx_p1[AW-1:0];
              more_d   = (idx_p1 < count_q);
              rd_vld_d = 1'b0;
              state_d  = S_SHIFT;
            end else begin
              state_d = S_OUT;
            end
          end else if (rd_idx_q == '0) begin
            status_d = ST_MISS;
            rec_d    = '0;
            state_d  = S_OUT;
          end
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves down one place
        rd_vld_d = more_q;
        rd_idx_d = ptr_q;
        if (more_q) begin
          ptr_d  = ptr_p1[AW-1:0];
          more_d = (ptr_p1 < count_q);
        end
        if (rd_vld_q) begin
          ram_we = 1'b1;
        end
        if (!more_q && !rd_vld_q) begin
          count_d = cnt_m1;
          total_d = total_q - TOT_W'(rec_q.score);
          state_d = S_OUT;
        end
      end
      S_AVG: begin
        if (div_done) begin
          mean_d  = div_quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({mean_q, count_q, rec_q.series, rec_q.score, rec_q.id, status_q});
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      total_q   <= '0;
      more_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      total_q   <= total_d;
      more_q    <= more_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    extract_q <= extract_d;
    ptr_q     <= ptr_d;
    rd_idx_q  <= rd_idx_d;
    status_q  <= status_d;
    rec_q     <= rec_d;
    mean_q    <= mean_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== rtl/rsk_ram.sv =====
`default_nettype none
module rsk_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/rsk_div.sv =====
`default_nettype none
module rsk_div #(
  parameter  int unsigned DEN_W  = 5,
  parameter  int unsigned Q_W    = 10,
  localparam int unsigned NUM_W  = DEN_W + Q_W,
  localparam int unsigned STEP_W = $clog2(Q_W + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [Q_W-1:0]   quot_o
);

  // restoring division, one quotient bit a cycle; caller guarantees quotient fits Q_W
  logic [DEN_W-1:0]  rem_q;
  logic [Q_W-1:0]    low_q;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, low_q[Q_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1:Q_W];
      low_q <= num_i[Q_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_q <= {low_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule
`default_nettype wire

// ===== rtl/rsk_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module rsk_assertions
  import rsk_pkg::*;
#(
  parameter  int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OUT_W       = out_width(CNT_W)
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned DEPTH_LSB = STATUS_W + REC_W;
  localparam int unsigned MEAN_LSB  = DEPTH_LSB + CNT_W;

  status_e           o_status;
  logic [REC_W-1:0]  o_rec;
  logic [CNT_W-1:0]  o_depth;
  logic [MEAN_W-1:0] o_mean;

  assign o_status = status_e'(m_axis_tdata[STATUS_W-1:0]);
  assign o_rec    = m_axis_tdata[STATUS_W +: REC_W];
  assign o_depth  = m_axis_tdata[DEPTH_LSB +: CNT_W];
  assign o_mean   = m_axis_tdata[MEAN_LSB +: MEAN_W];

  `RSK_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")
  `RSK_ASSERT_IMP(a_depth_bound, clk_i, rst_ni, m_axis_tvalid,
                  o_depth <= CNT_W'(STACK_DEPTH), "depth beyond capacity")
  `RSK_ASSERT_IMP(a_full_empty, clk_i, rst_ni, m_axis_tvalid && o_status == ST_FULL,
                  o_rec == '0 && o_mean == '0 && o_depth == CNT_W'(STACK_DEPTH),
                  "dropped push reports data or wrong depth")
  `RSK_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                  !s_axis_tready, "item taken while an operation is in progress")

endmodule

bind record_stack_with_keyed_removal rsk_assertions #(.STACK_DEPTH(STACK_DEPTH)) u_rsk_checker (.*);
`default_nettype wire

// ===== sim/rsk_checker.sv =====
`timescale 1ns / 100ps
module rsk_checker
  import rsk_pkg::*;
#(
  parameter  int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OUT_W       = out_width(CNT_W)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic             s_tready_i,
  input  wire logic [IN_W-1:0]  s_tdata_i,
  input  wire logic             m_tvalid_i,
  input  wire logic             m_tready_i,
  input  wire logic [OUT_W-1:0] m_tdata_i,
  output int                    mismatch_cnt_o,
  output int                    results_owed_o
);

  localparam int unsigned O_KEY  = FUNC_W;
  localparam int unsigned O_SCO  = O_KEY + ID_W;
  localparam int unsigned O_SER  = O_SCO + SCORE_W;

  localparam int unsigned R_ID   = STATUS_W;
  localparam int unsigned R_SCO  = R_ID + ID_W;
  localparam int unsigned R_SER  = R_SCO + SCORE_W;
  localparam int unsigned R_DEP  = R_SER + SERIES_W;
  localparam int unsigned R_MEAN = R_DEP + CNT_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [SCORE_W-1:0]  score;
    logic [SERIES_W-1:0] series;
    logic [CNT_W-1:0]    depth;
    logic [MEAN_W-1:0]   mean;
  } stack_result_t;

  logic [ID_W-1:0]     shadow_id     [STACK_DEPTH];
  logic [SCORE_W-1:0]  shadow_score  [STACK_DEPTH];
  logic [SERIES_W-1:0] shadow_series [STACK_DEPTH];
  int unsigned         shadow_count;
  int unsigned         shadow_total;

  stack_result_t owed_results_q[$];
  int            mismatch_cnt;

  assign mismatch_cnt_o = mismatch_cnt;
  assign results_owed_o = owed_results_q.size();

  // topmost entry holding the key, -1 on a miss
  function automatic int find_topmost(logic [ID_W-1:0] key);
    int idx;
    for (idx = int'(shadow_count) - 1; idx >= 0; idx--) begin
      if (shadow_id[idx] == key) return idx;
    end
    return -1;
  endfunction

  function automatic stack_result_t apply_stack_op(logic [IN_W-1:0] item);
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     key;
    logic [SCORE_W-1:0]  sco;
    logic [SERIES_W-1:0] ser;
    stack_result_t       res;
    int                  pos;
    func = item[0 +: FUNC_W];
    key  = item[O_KEY +: ID_W];
    sco  = item[O_SCO +: SCORE_W];
    ser  = item[O_SER +: SERIES_W];
    res  = '0;
    res.status = ST_OK;
    case (func)
      FUNC_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_id[shadow_count]     = key;
          shadow_score[shadow_count]  = sco;
          shadow_series[shadow_count] = ser;
          shadow_count++;
          shadow_total += sco;
        end
      end
      FUNC_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_MISS;
        end else begin
          shadow_count--;
          res.id     = shadow_id[shadow_count];
          res.score  = shadow_score[shadow_count];
          res.series = shadow_series[shadow_count];
          shadow_total -= res.score;
        end
      end
      FUNC_LOOKUP, FUNC_EXTRACT: begin
        pos = find_topmost(key);
        if (pos < 0) begin
          res.status = ST_MISS;
        end else begin
          res.id     = shadow_id[pos];
          res.score  = shadow_score[pos];
          res.series = shadow_series[pos];
          if (func == FUNC_EXTRACT) begin
            for (int k = pos; k + 1 < int'(shadow_count); k++) begin
              shadow_id[k]     = shadow_id[k+1];
              shadow_score[k]  = shadow_score[k+1];
              shadow_series[k] = shadow_series[k+1];
            end
            shadow_count--;
            shadow_total -= res.score;
          end
        end
      end
      FUNC_AVERAGE: begin
        if (shadow_count != 0) res.mean = MEAN_W'(shadow_total / shadow_count);
      end
      default: ;
    endcase
    res.depth = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t exp_r;
    if (!rst_ni) begin
      owed_results_q.delete();
      shadow_count = 0;
      shadow_total = 0;
      mismatch_cnt = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) owed_results_q.push_back(apply_stack_op(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (owed_results_q.size() == 0) begin
          $error("result item with no operation outstanding");
          mismatch_cnt++;
        end else begin
          exp_r = owed_results_q.pop_front();
          check_field("status",     exp_r.status, m_tdata_i[0 +: STATUS_W]);
          check_field("out_id",     exp_r.id,     m_tdata_i[R_ID +: ID_W]);
          check_field("out_score",  exp_r.score,  m_tdata_i[R_SCO +: SCORE_W]);
          check_field("out_series", exp_r.series, m_tdata_i[R_SER +: SERIES_W]);
          check_field("depth_now",  exp_r.depth,  m_tdata_i[R_DEP +: CNT_W]);
          check_field("mean_score", exp_r.mean,   m_tdata_i[R_MEAN +: MEAN_W]);
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import rsk_pkg::*;

  localparam int unsigned CNT_W        = $clog2(DEF_STACK_DEPTH + 1);
  localparam int unsigned OUT_W        = out_width(CNT_W);
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 320;
  localparam int unsigned SWING_ITEMS  = 40;
  localparam logic [FUNC_W-1:0] FUNC_NOP_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_NOP_HI = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  int          mismatch_cnt;
  int          results_owed;
  int unsigned cycle_cnt;
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;

  record_stack_with_keyed_removal DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rsk_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .mismatch_cnt_o (mismatch_cnt),
    .results_owed_o (results_owed)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge once the item is taken
  task automatic send_item(logic [FUNC_W-1:0] func, logic [ID_W-1:0] key,
                           logic [SCORE_W-1:0] sco, logic [SERIES_W-1:0] ser);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({ser, sco, key, func});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly a small pool of ids so lookups and extracts hit
  function automatic logic [ID_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return ID_W'($urandom_range(0, 5));
    if (r < 75) return '1;
    return ID_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return SCORE_W'(1000);
    return SCORE_W'($urandom_range(0, 1000));
  endfunction

  task automatic random_item(bit filling);
    int unsigned       r;
    logic [FUNC_W-1:0] func;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 60)      func = FUNC_PUSH;
      else if (r < 70) func = FUNC_POP;
      else if (r < 82) func = FUNC_LOOKUP;
      else if (r < 94) func = FUNC_EXTRACT;
      else if (r < 99) func = FUNC_AVERAGE;
      else             func = FUNC_W'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI));
    end else begin
      if (r < 15)      func = FUNC_PUSH;
      else if (r < 55) func = FUNC_POP;
      else if (r < 70) func = FUNC_LOOKUP;
      else if (r < 90) func = FUNC_EXTRACT;
      else if (r < 98) func = FUNC_AVERAGE;
      else             func = FUNC_W'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI));
    end
    send_item(func, pick_key(), pick_score(), SERIES_W'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) random_item(((n / SWING_ITEMS) % 2) == 0);
    // hold off until the block has drained
    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    cycle_cnt     = 0;
    rst_ni        = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty stack cases and unused codes
    send_item(FUNC_POP,     '0, '0, '0);
    send_item(FUNC_LOOKUP,  '0, '0, '0);
    send_item(FUNC_EXTRACT, '1, '0, '0);
    send_item(FUNC_AVERAGE, '0, '0, '0);
    send_item(FUNC_NOP_LO,  '1, SCORE_W'(1000), '1);
    send_item(FUNC_NOP_HI,  '0, '0, '0);
    // fill with repeated ids, extremes at bottom and top
    for (int unsigned i = 0; i < DEF_STACK_DEPTH; i++) begin
      send_item(FUNC_PUSH,
                (i == 0) ? ID_W'(0) : (i == DEF_STACK_DEPTH - 1) ? '1 : ID_W'(i % 4),
                (i == 0) ? SCORE_W'(0) : (i == DEF_STACK_DEPTH - 1) ? SCORE_W'(1000)
                                                                    : SCORE_W'(i * 61),
                (i == DEF_STACK_DEPTH - 1) ? '1 : SERIES_W'(i * 3));
    end
    send_item(FUNC_PUSH,    16'h5A5A, SCORE_W'(500), 8'hA5);
    send_item(FUNC_LOOKUP,  ID_W'(2), '0, '0);
    send_item(FUNC_LOOKUP,  16'h1234, '0, '0);
    send_item(FUNC_EXTRACT, ID_W'(1), '0, '0);
    send_item(FUNC_AVERAGE, '0, '0, '0);
    send_item(FUNC_POP,     '0, '0, '0);
    send_item(FUNC_EXTRACT, ID_W'(0), '0, '0);
    send_item(FUNC_AVERAGE, '0, '0, '0);
    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);

    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(38, 38);

    repeat (64) @(negedge clk_i);
    if (mismatch_cnt == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== record_stack_with_keyed_removal.f =====
+incdir+rtl
rtl/rsk_pkg.sv
rtl/rsk_ram.sv
rtl/rsk_div.sv
rtl/record_stack_with_keyed_removal.sv
rtl/rsk_checker.sv
sim/rsk_checker.sv
sim/tb_top.sv
